// ===== rtl/smm_pkg.sv =====
package smm_pkg;

  localparam int unsigned IDX_W       = 3;
  localparam int unsigned ELEM_PORT_W = 16;
  localparam int unsigned PROD_W      = 34;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } op_e;

  typedef enum logic {
    MTX_FIRST  = 1'b0,
    MTX_SECOND = 1'b1
  } mtx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic wr_first;
    logic wr_second;
    logic rd_en;
    logic k_first;
    logic k_last;
    logic entry_last;
  } cmd_t;

  typedef struct packed {
    logic out_taken;
  } status_t;

endpackage

// ===== rtl/smm_ram.sv =====
module smm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 25
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/smm_ctrl.sv =====
module smm_ctrl #(
  parameter int unsigned DIM = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                operation_i,
  input  logic                                which_matrix_i,
  input  logic [smm_pkg::IDX_W-1:0]           row_index_i,
  input  logic [smm_pkg::IDX_W-1:0]           col_index_i,
  input  smm_pkg::status_t                    status_i,
  output logic                                in_stall_o,
  output smm_pkg::cmd_t                       cmd_o,
  output logic [$clog2(DIM)-1:0]              r_o,
  output logic [$clog2(DIM)-1:0]              c_o,
  output logic [$clog2(DIM)-1:0]              k_o
);

  localparam int unsigned IW = $clog2(DIM);
  localparam logic [IW-1:0] LAST_IDX = IW'(DIM - 1);

  smm_pkg::state_e state_q, state_d;
  logic [IW-1:0]   r_q, r_d, c_q, c_d, k_q, k_d;
  logic            idle_beat;
  logic            in_range;
  logic            entry_last;

  assign idle_beat  = in_valid_i && (state_q == smm_pkg::ST_IDLE);
  assign in_range   = (int'(row_index_i) < DIM) && (int'(col_index_i) < DIM);
  assign entry_last = (r_q == LAST_IDX) && (c_q == LAST_IDX);

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    k_d     = k_q;
    unique case (state_q)
      smm_pkg::ST_IDLE: begin
        if (idle_beat && (operation_i == smm_pkg::OP_COMPUTE)) begin
          state_d = smm_pkg::ST_ISSUE;
          r_d     = '0;
          c_d     = '0;
          k_d     = '0;
        end
      end
      smm_pkg::ST_ISSUE: begin
        if (k_q == LAST_IDX) begin
          k_d     = '0;
          state_d = smm_pkg::ST_WAIT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      smm_pkg::ST_WAIT: begin
        if (status_i.out_taken) begin
          if (entry_last) begin
            state_d = smm_pkg::ST_IDLE;
          end else begin
            state_d = smm_pkg::ST_ISSUE;
            if (c_q == LAST_IDX) begin
              c_d = '0;
              r_d = r_q + 1'b1;
            end else begin
              c_d = c_q + 1'b1;
            end
          end
        end
      end
      default: state_d = smm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o         = (state_q != smm_pkg::ST_IDLE);
    cmd_o.wr_first     = idle_beat && (operation_i == smm_pkg::OP_LOAD) && in_range &&
                         (which_matrix_i == smm_pkg::MTX_FIRST);
    cmd_o.wr_second    = idle_beat && (operation_i == smm_pkg::OP_LOAD) && in_range &&
                         (which_matrix_i == smm_pkg::MTX_SECOND);
    cmd_o.rd_en        = (state_q == smm_pkg::ST_ISSUE);
    cmd_o.k_first      = (k_q == '0);
    cmd_o.k_last       = (k_q == LAST_IDX);
    cmd_o.entry_last   = entry_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smm_pkg::ST_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
    end
  end

  assign r_o = r_q;
  assign c_o = c_q;
  assign k_o = k_q;

endmodule

// ===== rtl/smm_dp.sv =====
module smm_dp #(
  parameter int unsigned DIM        = 5,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  smm_pkg::cmd_t                           cmd_i,
  input  logic [$clog2(DIM)-1:0]                  r_i,
  input  logic [$clog2(DIM)-1:0]                  c_i,
  input  logic [$clog2(DIM)-1:0]                  k_i,
  input  logic [smm_pkg::IDX_W-1:0]               row_index_i,
  input  logic [smm_pkg::IDX_W-1:0]               col_index_i,
  input  logic signed [smm_pkg::ELEM_PORT_W-1:0]  element_value_i,
  input  logic                                    out_stall_i,
  output smm_pkg::status_t                        status_o,
  output logic                                    out_valid_o,
  output logic [smm_pkg::IDX_W-1:0]               out_row_o,
  output logic [smm_pkg::IDX_W-1:0]               out_col_o,
  output logic signed [smm_pkg::PROD_W-1:0]       product_value_o,
  output logic                                    last_entry_o
);

  localparam int unsigned DEPTH = DIM * DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned MW    = 2 * ELEM_WIDTH;
  localparam int unsigned EXT_W = (MW > smm_pkg::PROD_W) ? MW : smm_pkg::PROD_W;

  logic [AW-1:0]                   waddr;
  logic [AW-1:0]                   raddr_first;
  logic [AW-1:0]                   raddr_second;
  logic [ELEM_WIDTH-1:0]           wdata;
  logic [ELEM_WIDTH-1:0]           rdata_first;
  logic [ELEM_WIDTH-1:0]           rdata_second;
  logic signed [ELEM_WIDTH-1:0]    op_a;
  logic signed [ELEM_WIDTH-1:0]    op_b;
  logic signed [MW-1:0]            prod_q;
  logic signed [EXT_W-1:0]         prod_ext;
  logic [smm_pkg::PROD_W-1:0]      prod_trim;
  logic [smm_pkg::PROD_W-1:0]      acc_q, acc_d;
  logic                            s1_valid_q, s1_first_q, s1_last_q;
  logic                            s2_valid_q, s2_first_q, s2_last_q;
  logic                            out_valid_q;
  logic                            out_load;
  logic                            out_taken;

  assign waddr        = AW'(int'(row_index_i) * DIM + int'(col_index_i));
  assign wdata        = ELEM_WIDTH'($unsigned(element_value_i));
  assign raddr_second = AW'(int'(r_i) * DIM + int'(k_i));
  assign raddr_first  = AW'(int'(k_i) * DIM + int'(c_i));

  smm_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_first (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_first),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_first),
    .rdata_o (rdata_first)
  );

  smm_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_second (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_second),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_second),
    .rdata_o (rdata_second)
  );

  assign op_a      = $signed(rdata_second);
  assign op_b      = $signed(rdata_first);
  assign prod_ext  = EXT_W'(prod_q);
  assign prod_trim = prod_ext[smm_pkg::PROD_W-1:0];
  assign acc_d     = s2_first_q ? prod_trim : (acc_q + prod_trim);
  assign out_load  = s2_valid_q && s2_last_q;
  assign out_taken = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    if (s2_valid_q) begin
      acc_q <= acc_d;
    end
    if (out_load) begin
      product_value_o <= $signed(acc_d);
      out_row_o       <= smm_pkg::IDX_W'(r_i);
      out_col_o       <= smm_pkg::IDX_W'(c_i);
      last_entry_o    <= cmd_i.entry_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_first_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_valid_q  <= 1'b0;
      s2_first_q  <= 1'b0;
      s2_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.rd_en;
      s1_first_q <= cmd_i.k_first;
      s1_last_q  <= cmd_i.k_last;
      s2_valid_q <= s1_valid_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_taken) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_taken = out_taken;
  assign out_valid_o        = out_valid_q;

endmodule

// ===== rtl/square_matrix_multiply_core.sv =====
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   operation, which_matrix, row/col, element
// out      source     out_valid_o / out_stall_i out_row, out_col, product_value, last_entry
//
// A load beat does not stall the input; the block takes the next beat right after it.
// A compute beat stalls the input until the last entry of the product is taken:
// each entry walks DIM reads of the two element RAMs through one multiplier and one
// accumulator, then waits for the read, multiply and output registers.
// An output stall holds the walk until the pending entry is taken.
// rst_ni clears control only; element storage is undefined until loaded.
module square_matrix_multiply_core #(
  parameter int unsigned DIM        = 5,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    operation_i,
  input  logic                                    which_matrix_i,
  input  logic [smm_pkg::IDX_W-1:0]               row_index_i,
  input  logic [smm_pkg::IDX_W-1:0]               col_index_i,
  input  logic signed [smm_pkg::ELEM_PORT_W-1:0]  element_value_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [smm_pkg::IDX_W-1:0]               out_row_o,
  output logic [smm_pkg::IDX_W-1:0]               out_col_o,
  output logic signed [smm_pkg::PROD_W-1:0]       product_value_o,
  output logic                                    last_entry_o
);

  localparam int unsigned IW = $clog2(DIM);

  smm_pkg::cmd_t    cmd;
  smm_pkg::status_t status;
  logic [IW-1:0]    r_idx, c_idx, k_idx;

  smm_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .operation_i    (operation_i),
    .which_matrix_i (which_matrix_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .status_i       (status),
    .in_stall_o     (in_stall_o),
    .cmd_o          (cmd),
    .r_o            (r_idx),
    .c_o            (c_idx),
    .k_o            (k_idx)
  );

  smm_dp #(
    .DIM        (DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .r_i             (r_idx),
    .c_i             (c_idx),
    .k_i             (k_idx),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .out_stall_i     (out_stall_i),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .last_entry_o    (last_entry_o)
  );

endmodule

// ===== rtl/smm_chk.sv =====
module smm_chk (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid_i,
  input logic                                    in_stall_o,
  input logic                                    operation_i,
  input logic                                    out_valid_o,
  input logic                                    out_stall_i,
  input logic signed [smm_pkg::PROD_W-1:0]       product_value_o,
  input logic                                    last_entry_o
);

  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(product_value_o) && $stable(last_entry_o)))
    else $error("stalled output beat changed");

  a_idle_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("output pending while input is open");

  a_compute_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (operation_i == smm_pkg::OP_COMPUTE)) |=> in_stall_o)
    else $error("compute beat did not stall the input");

  a_load_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (operation_i == smm_pkg::OP_LOAD)) |=> !in_stall_o)
    else $error("load beat stalled the input");

  a_last_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && last_entry_o) |=> !in_stall_o)
    else $error("input still stalled after last entry");

endmodule

bind square_matrix_multiply_core smm_chk u_smm_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .operation_i     (operation_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .product_value_o (product_value_o),
  .last_entry_o    (last_entry_o)
);
